[src/cbz_pkg.sv]
// ----------------------------------------------------------------------------
// cbz_pkg
// Shared types and fixed-point constants for the cubic Bezier point evaluator.
// ----------------------------------------------------------------------------
package cbz_pkg;

  // curve parameter t: unsigned, 16 fraction bits, one integer bit so 1.0 is exact
  localparam int T_FRAC    = 16;
  localparam int T_BITS    = T_FRAC + 1;
  localparam int SQ_BITS   = 2 * T_FRAC + 1;   // u*u, t*t
  localparam int CUBE_BITS = 3 * T_FRAC + 1;   // u*u*u and friends
  localparam int RAW_BITS  = CUBE_BITS + 2;    // room for the factor of three

  // weights are rounded from 48 to 30 fraction bits
  localparam int W_SHIFT   = 18;
  localparam int W_BITS    = 31;
  localparam int ACC_SHIFT = 30;

  localparam int BERN_3    = 3;

  localparam int NUM_REGS     = 8;
  localparam int CFG_IDX_BITS = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_P0_X = 3'd0,
    REG_P0_Y = 3'd1,
    REG_P1_X = 3'd2,
    REG_P1_Y = 3'd3,
    REG_P2_X = 3'd4,
    REG_P2_Y = 3'd5,
    REG_P3_X = 3'd6,
    REG_P3_Y = 3'd7
  } cfg_reg_t;

  // reset values of the control points, Q12.4
  localparam int PT_RST [NUM_REGS] = '{6400, 9600, 8000, 3200, 12800, 3200, 14400, 9600};

  typedef logic [W_BITS-1:0] weight_t;

  // sideband that travels with every item through the pipe
  typedef struct packed {
    logic is_last;
    logic zero_cnt;
  } cbz_side_t;

endpackage

[src/cbz_in_if.sv]
// ----------------------------------------------------------------------------
// cbz_in_if
// Input channel: step index and step count with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface cbz_in_if #(
  parameter int STEP_BITS = 12
) ();
  logic                 valid;
  logic                 ready;
  logic [STEP_BITS-1:0] step_index;
  logic [STEP_BITS-1:0] step_count;

  modport source (output valid, step_index, step_count, input ready);
  modport sink   (input valid, step_index, step_count, output ready);
endinterface

[src/cbz_out_if.sv]
// ----------------------------------------------------------------------------
// cbz_out_if
// Result channel: curve point and last flag with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface cbz_out_if #(
  parameter int COORD_BITS = 16
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic                         is_last;

  modport source (output valid, point_x, point_y, is_last, input ready);
  modport sink   (input valid, point_x, point_y, is_last, output ready);
endinterface

[src/cbz_div.sv]
// ----------------------------------------------------------------------------
// cbz_div
// Pipelined restoring divider: t = floor(i * 2^16 / n), one quotient bit per
// stage, with the index clamped to the count at entry.
// ----------------------------------------------------------------------------
module cbz_div #(
  parameter int STEP_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [STEP_BITS-1:0]          step_index,
  input  logic [STEP_BITS-1:0]          step_count,
  output logic                          out_valid,
  output logic [cbz_pkg::T_BITS-1:0]    t_out,
  output cbz_pkg::cbz_side_t            side_out
);

  localparam int NSTG = cbz_pkg::T_FRAC + 1;

  logic [NSTG-1:0]            v_r;
  logic [STEP_BITS-1:0]       n_r   [NSTG-1];
  logic [STEP_BITS-1:0]       rem_r [NSTG-1];
  logic [cbz_pkg::T_BITS-1:0] q_r   [NSTG];
  cbz_pkg::cbz_side_t         side_r [NSTG];

  // one quotient bit per stage, computed from the stage before it
  logic [STEP_BITS:0]   rem2 [NSTG-1];
  logic [STEP_BITS-1:0] diff [NSTG-1];
  logic [NSTG-2:0]      ge;

  logic at_end;

  // i >= n: clamped index equals n, so the integer quotient bit is one
  assign at_end = (step_index >= step_count);

  always_comb begin
    for (int j = 0; j < NSTG - 1; j++) begin
      rem2[j] = {rem_r[j], 1'b0};
      diff[j] = rem2[j][STEP_BITS-1:0] - n_r[j];
      ge[j]   = (rem2[j] >= {1'b0, n_r[j]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NSTG-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r[0]             <= step_count;
      rem_r[0]           <= at_end ? '0 : step_index;
      q_r[0]             <= {{cbz_pkg::T_FRAC{1'b0}}, at_end};
      side_r[0].is_last  <= at_end;
      side_r[0].zero_cnt <= (step_count == '0);
      for (int j = 1; j < NSTG - 1; j++) begin
        n_r[j]   <= n_r[j-1];
        rem_r[j] <= ge[j-1] ? diff[j-1] : rem2[j-1][STEP_BITS-1:0];
      end
      for (int j = 1; j < NSTG; j++) begin
        q_r[j]    <= {q_r[j-1][cbz_pkg::T_BITS-2:0], ge[j-1]};
        side_r[j] <= side_r[j-1];
      end
    end
  end

  assign out_valid = v_r[NSTG-1];
  assign t_out     = q_r[NSTG-1];
  assign side_out  = side_r[NSTG-1];

endmodule

[src/cbz_weight.sv]
// ----------------------------------------------------------------------------
// cbz_weight
// Bernstein weights u^3, 3u^2t, 3ut^2, t^3 in four register stages, rounded
// to 30 fraction bits.
// ----------------------------------------------------------------------------
module cbz_weight (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [cbz_pkg::T_BITS-1:0] t_in,
  input  cbz_pkg::cbz_side_t         side_in,
  output logic                       out_valid,
  output cbz_pkg::weight_t           w_out [4],
  output cbz_pkg::cbz_side_t         side_out
);

  localparam int TB = cbz_pkg::T_BITS;
  localparam int SB = cbz_pkg::SQ_BITS;
  localparam int CB = cbz_pkg::CUBE_BITS;
  localparam int RB = cbz_pkg::RAW_BITS;
  localparam logic [TB-1:0] T_ONE = TB'(1) << cbz_pkg::T_FRAC;
  localparam logic [RB-1:0] W_RND = RB'(1) << (cbz_pkg::W_SHIFT - 1);

  logic [3:0]         v_r;
  cbz_pkg::cbz_side_t side_r [4];

  logic [TB-1:0] t_a_r, u_a_r;
  logic [TB-1:0] t_b_r, u_b_r;
  logic [SB-1:0] uu_b_r, tt_b_r;
  logic [CB-1:0] c_r [4];
  logic [RB-1:0] sum [4];
  cbz_pkg::weight_t w_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[2:0], in_valid};
    end
  end

  always_comb begin
    sum[0] = RB'(c_r[0]) + W_RND;
    sum[1] = RB'(c_r[1]) * RB'(cbz_pkg::BERN_3) + W_RND;
    sum[2] = RB'(c_r[2]) * RB'(cbz_pkg::BERN_3) + W_RND;
    sum[3] = RB'(c_r[3]) + W_RND;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage A: t and u = 1 - t
      t_a_r     <= t_in;
      u_a_r     <= T_ONE - t_in;
      side_r[0] <= side_in;
      // stage B: squares
      t_b_r     <= t_a_r;
      u_b_r     <= u_a_r;
      uu_b_r    <= SB'(u_a_r) * SB'(u_a_r);
      tt_b_r    <= SB'(t_a_r) * SB'(t_a_r);
      side_r[1] <= side_r[0];
      // stage C: cubes
      c_r[0]    <= CB'(uu_b_r) * CB'(u_b_r);
      c_r[1]    <= CB'(uu_b_r) * CB'(t_b_r);
      c_r[2]    <= CB'(tt_b_r) * CB'(u_b_r);
      c_r[3]    <= CB'(tt_b_r) * CB'(t_b_r);
      side_r[2] <= side_r[1];
      // stage D: scale and round
      for (int k = 0; k < 4; k++) begin
        w_r[k] <= sum[k][cbz_pkg::W_SHIFT +: cbz_pkg::W_BITS];
      end
      side_r[3] <= side_r[2];
    end
  end

  assign out_valid = v_r[3];
  assign w_out     = w_r;
  assign side_out  = side_r[3];

endmodule

[src/cbz_mac.sv]
// ----------------------------------------------------------------------------
// cbz_mac
// Weighted sum of the four control points in x and y: multiply, add tree,
// round half up and saturate to the coordinate range.
// ----------------------------------------------------------------------------
module cbz_mac #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  cbz_pkg::weight_t             w_in [4],
  input  cbz_pkg::cbz_side_t           side_in,
  input  logic signed [COORD_BITS-1:0] pt [cbz_pkg::NUM_REGS],
  output logic                         out_valid,
  output logic signed [COORD_BITS-1:0] x_out,
  output logic signed [COORD_BITS-1:0] y_out,
  output logic                         last_out
);

  localparam int PROD_BITS = cbz_pkg::W_BITS + 1 + COORD_BITS;
  localparam int SUM_BITS  = PROD_BITS + 2;
  localparam logic signed [SUM_BITS-1:0] ACC_RND = SUM_BITS'(1) << (cbz_pkg::ACC_SHIFT - 1);
  localparam logic [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  logic [3:0]         v_r;
  cbz_pkg::cbz_side_t side_r [3];

  logic signed [COORD_BITS-1:0] px [4];
  logic signed [COORD_BITS-1:0] py [4];
  logic signed [cbz_pkg::W_BITS:0] ws [4];

  logic signed [PROD_BITS-1:0]  prod_r [2][4];
  logic signed [PROD_BITS:0]    pair_r [2][2];
  logic signed [SUM_BITS-1:0]   acc_r  [2];
  logic signed [SUM_BITS-1:0]   sh     [2];
  logic [COORD_BITS-1:0]        sat    [2];
  logic signed [COORD_BITS-1:0] x_r, y_r;
  logic                         last_r;

  always_comb begin
    px[0] = pt[cbz_pkg::REG_P0_X];
    px[1] = pt[cbz_pkg::REG_P1_X];
    px[2] = pt[cbz_pkg::REG_P2_X];
    px[3] = pt[cbz_pkg::REG_P3_X];
    py[0] = pt[cbz_pkg::REG_P0_Y];
    py[1] = pt[cbz_pkg::REG_P1_Y];
    py[2] = pt[cbz_pkg::REG_P2_Y];
    py[3] = pt[cbz_pkg::REG_P3_Y];
    for (int k = 0; k < 4; k++) begin
      ws[k] = $signed({1'b0, w_in[k]});
    end
  end

  // floor shift, then clamp when the upper bits are not a sign extension
  always_comb begin
    for (int c = 0; c < 2; c++) begin
      sh[c] = acc_r[c] >>> cbz_pkg::ACC_SHIFT;
      if ((&sh[c][SUM_BITS-1:COORD_BITS-1]) || !(|sh[c][SUM_BITS-1:COORD_BITS-1])) begin
        sat[c] = sh[c][COORD_BITS-1:0];
      end else if (sh[c][SUM_BITS-1]) begin
        sat[c] = C_MIN;
      end else begin
        sat[c] = C_MAX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        prod_r[0][k] <= ws[k] * px[k];
        prod_r[1][k] <= ws[k] * py[k];
      end
      side_r[0] <= side_in;
      for (int c = 0; c < 2; c++) begin
        pair_r[c][0] <= (PROD_BITS+1)'(prod_r[c][0]) + (PROD_BITS+1)'(prod_r[c][1]);
        pair_r[c][1] <= (PROD_BITS+1)'(prod_r[c][2]) + (PROD_BITS+1)'(prod_r[c][3]);
        acc_r[c]     <= SUM_BITS'(pair_r[c][0]) + SUM_BITS'(pair_r[c][1]) + ACC_RND;
      end
      side_r[1] <= side_r[0];
      side_r[2] <= side_r[1];
      // zero count passes the start point through unchanged
      x_r    <= side_r[2].zero_cnt ? pt[cbz_pkg::REG_P0_X] : $signed(sat[0]);
      y_r    <= side_r[2].zero_cnt ? pt[cbz_pkg::REG_P0_Y] : $signed(sat[1]);
      last_r <= side_r[2].is_last;
    end
  end

  assign out_valid = v_r[3];
  assign x_out     = x_r;
  assign y_out     = y_r;
  assign last_out  = last_r;

endmodule

[src/cubic_bezier_point_eval.sv]
// ----------------------------------------------------------------------------
// cubic_bezier_point_eval
// Cubic Bezier point evaluator: t = i/n, Bernstein weights, weighted sum of
// four configurable control points, rounded and saturated.
// ----------------------------------------------------------------------------
// Takes one (step_index, step_count) transaction per clock and returns one
// curve point per clock in the same order while the result sink keeps up.
// The pipe holds 17 divider stages (one quotient bit of t each), 4 weight
// stages, 4 multiply/add stages and the output register. The whole
// pipe advances together while the two-entry output buffer has room; a
// stalled result sink fills the buffer and then holds in_chan.ready low.
// Control points are written through cfg_we/cfg_index/cfg_wdata; the user
// must write them only while no transaction is in flight (not enforced).
module cubic_bezier_point_eval #(
  parameter int STEP_BITS  = 12,
  parameter int COORD_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  cbz_in_if.sink                            in_chan,
  cbz_out_if.source                         out_chan,
  input  logic                              cfg_we,
  input  logic [cbz_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [COORD_BITS-1:0]             cfg_wdata
);

  logic signed [COORD_BITS-1:0] pt_r [cbz_pkg::NUM_REGS];

  logic                       en;
  logic                       div_valid, wgt_valid, mac_valid;
  logic [cbz_pkg::T_BITS-1:0] div_t;
  cbz_pkg::cbz_side_t         div_side, wgt_side;
  cbz_pkg::weight_t           wgt_w [4];
  logic signed [COORD_BITS-1:0] mac_x, mac_y;
  logic                       mac_last;

  logic                         out_valid_r, skid_valid_r;
  logic signed [COORD_BITS-1:0] ox_r, oy_r, sx_r, sy_r;
  logic                         olast_r, slast_r;
  logic                         pop, push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < cbz_pkg::NUM_REGS; k++) begin
        pt_r[k] <= COORD_BITS'(cbz_pkg::PT_RST[k]);
      end
    end else if (cfg_we) begin
      pt_r[cfg_index] <= cfg_wdata;
    end
  end

  // advance the pipe while the output buffer can take one more
  assign en            = !skid_valid_r;
  assign in_chan.ready = en;

  cbz_div #(
    .STEP_BITS (STEP_BITS)
  ) u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (in_chan.valid),
    .step_index (in_chan.step_index),
    .step_count (in_chan.step_count),
    .out_valid  (div_valid),
    .t_out      (div_t),
    .side_out   (div_side)
  );

  cbz_weight u_weight (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (div_valid),
    .t_in      (div_t),
    .side_in   (div_side),
    .out_valid (wgt_valid),
    .w_out     (wgt_w),
    .side_out  (wgt_side)
  );

  cbz_mac #(
    .COORD_BITS (COORD_BITS)
  ) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (wgt_valid),
    .w_in      (wgt_w),
    .side_in   (wgt_side),
    .pt        (pt_r),
    .out_valid (mac_valid),
    .x_out     (mac_x),
    .y_out     (mac_y),
    .last_out  (mac_last)
  );

  assign pop  = out_valid_r && out_chan.ready;
  assign push = mac_valid && en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_r && !pop) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r && pop) begin
      ox_r    <= sx_r;
      oy_r    <= sy_r;
      olast_r <= slast_r;
    end else if (push && (!out_valid_r || pop)) begin
      ox_r    <= mac_x;
      oy_r    <= mac_y;
      olast_r <= mac_last;
    end
    // hold the new result aside while the output register is still waiting
    if (push && out_valid_r && !pop) begin
      sx_r    <= mac_x;
      sy_r    <= mac_y;
      slast_r <= mac_last;
    end
  end

  assign out_chan.valid   = out_valid_r;
  assign out_chan.point_x = ox_r;
  assign out_chan.point_y = oy_r;
  assign out_chan.is_last = olast_r;

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the cubic Bezier point evaluator. A clocked driver
// feeds (step_index, step_count) transactions from a queue, and a clocked
// monitor computes the expected curve point for each accepted transaction and
// compares every returned point with it, in order. Control points are
// reloaded between phases: reset values, all-max, all-min, mixed extremes and
// random sets, with random idling on both channels and a long sink hold-off.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int STEP_W      = 12;
  localparam int COORD_W     = 16;
  localparam int IDLE_PCT    = 38;
  localparam int HOLD_LEN    = 300;
  localparam int QUIET_LIMIT = 3000;
  localparam int TAIL_CYCLES = 40;
  localparam int MAX_REPORTS = 10;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 200;

  // fixed-point layout of t and the weights
  localparam int          FRAC_T    = 16;
  localparam int          WGT_SHIFT = 18;
  localparam int          SUM_SHIFT = 30;
  localparam longint      COORD_MAX = 32767;
  localparam longint      COORD_MIN = -32768;

  typedef enum int {
    PTS_RANDOM,
    PTS_ALL_MAX,
    PTS_ALL_MIN,
    PTS_MIXED
  } pt_set_t;

  typedef struct {
    logic [STEP_W-1:0] idx;
    logic [STEP_W-1:0] cnt;
  } step_req_t;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      last;
  } curve_pt_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic                             cfg_we = 1'b0;
  logic [cbz_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [COORD_W-1:0]               cfg_wdata = '0;

  cbz_in_if  #(.STEP_BITS(STEP_W))   in_ch ();
  cbz_out_if #(.COORD_BITS(COORD_W)) out_ch ();

  cubic_bezier_point_eval #(
    .STEP_BITS  (STEP_W),
    .COORD_BITS (COORD_W)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_ch),
    .out_chan  (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // bench copy of the control point registers
  logic signed [COORD_W-1:0] ctrl_pt [cbz_pkg::NUM_REGS];

  step_req_t steps_to_send [$];
  curve_pt_t points_due [$];

  logic in_acc = 1'b0;
  bit   src_no_idle = 1'b0;
  bit   sink_no_idle = 1'b0;
  int   hold_arm = 0;
  int   hold_seen = 0;
  int   hold_left = 0;

  int bad_cnt = 0;
  int points_seen = 0;
  int zero_cnt_seen = 0;
  int clamp_seen = 0;
  int full_stall_cycles = 0;
  int pt_sets = 1;
  int quiet = 0;

  function automatic curve_pt_t bezier_point(logic [STEP_W-1:0] idx, logic [STEP_W-1:0] cnt);
    curve_pt_t      res;
    longint unsigned i, n, t, u;
    longint unsigned wgt [4];
    longint          acc;
    longint          rnd;
    int              c, k;
    i = idx;
    n = cnt;
    if (n == 0) begin
      res.x    = ctrl_pt[cbz_pkg::REG_P0_X];
      res.y    = ctrl_pt[cbz_pkg::REG_P0_Y];
      res.last = 1'b1;
      return res;
    end
    if (i > n) i = n;
    t = (i << FRAC_T) / n;
    u = (64'd1 << FRAC_T) - t;
    rnd = longint'(64'd1 << (WGT_SHIFT - 1));
    wgt[0] = (u * u * u + rnd) >> WGT_SHIFT;
    wgt[1] = (64'd3 * u * u * t + rnd) >> WGT_SHIFT;
    wgt[2] = (64'd3 * u * t * t + rnd) >> WGT_SHIFT;
    wgt[3] = (t * t * t + rnd) >> WGT_SHIFT;
    for (c = 0; c < 2; c++) begin
      acc = 0;
      for (k = 0; k < 4; k++)
        acc += longint'(wgt[k]) * longint'(ctrl_pt[2 * k + c]);
      acc += longint'(1) << (SUM_SHIFT - 1);
      acc = acc >>> SUM_SHIFT;
      if (acc > COORD_MAX) acc = COORD_MAX;
      if (acc < COORD_MIN) acc = COORD_MIN;
      if (c == 0) res.x = acc[COORD_W-1:0];
      else        res.y = acc[COORD_W-1:0];
    end
    res.last = (i >= n);
    return res;
  endfunction

  // driver: advance to the next transaction once the current one is taken
  always @(negedge clk) begin : drive_in
    step_req_t req;
    if (rst_n && (!in_ch.valid || in_acc)) begin
      if (steps_to_send.size() != 0 && (src_no_idle || $urandom_range(99) >= IDLE_PCT)) begin
        req = steps_to_send.pop_front();
        in_ch.valid      <= 1'b1;
        in_ch.step_index <= req.idx;
        in_ch.step_count <= req.cnt;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver: random ready, with a long counted hold-off on request
  always @(negedge clk) begin : drive_ready
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_arm != hold_seen) begin
      hold_seen    <= hold_arm;
      hold_left    <= HOLD_LEN;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= sink_no_idle || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin : watch_ports
    curve_pt_t want;
    curve_pt_t due;
    bit        in_fire, out_fire;
    in_fire  = rst_n && in_ch.valid && in_ch.ready;
    out_fire = rst_n && out_ch.valid && out_ch.ready;
    in_acc <= in_fire;
    if (rst_n && in_ch.valid && !in_ch.ready) full_stall_cycles++;
    if (in_fire) begin
      due = bezier_point(in_ch.step_index, in_ch.step_count);
      points_due = {points_due, due};
      if (in_ch.step_count == 0) zero_cnt_seen++;
      else if (in_ch.step_index > in_ch.step_count) clamp_seen++;
    end
    if (out_fire) begin
      points_seen++;
      if (points_due.size() == 0) begin
        bad_cnt++;
        if (bad_cnt <= MAX_REPORTS)
          $display("[%0t] unexpected point x=%0d y=%0d last=%0b", $realtime,
                   out_ch.point_x, out_ch.point_y, out_ch.is_last);
      end else begin
        want = points_due.pop_front();
        if (out_ch.point_x !== want.x || out_ch.point_y !== want.y ||
            out_ch.is_last !== want.last) begin
          bad_cnt++;
          if (bad_cnt <= MAX_REPORTS)
            $display("[%0t] point mismatch: expected x=%0d y=%0d last=%0b, %s",
                     $realtime, want.x, want.y, want.last,
                     $sformatf("got x=%0d y=%0d last=%0b",
                               out_ch.point_x, out_ch.point_y, out_ch.is_last));
        end
      end
    end
    if (in_fire || out_fire) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("[%0t] watchdog: no transaction for %0d cycles", $realtime, QUIET_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic add_step(int idx, int cnt);
    step_req_t req;
    req.idx = idx[STEP_W-1:0];
    req.cnt = cnt[STEP_W-1:0];
    steps_to_send = {steps_to_send, req};
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (steps_to_send.size() != 0 || in_ch.valid || points_due.size() != 0);
  endtask

  task automatic load_points(pt_set_t kind);
    int                 k;
    logic [COORD_W-1:0] val;
    for (k = 0; k < cbz_pkg::NUM_REGS; k++) begin
      case (kind)
        PTS_ALL_MAX: val = 16'h7fff;
        PTS_ALL_MIN: val = 16'h8000;
        PTS_MIXED:   val = (k[0] ^ k[1]) ? 16'h8000 : 16'h7fff;
        default:     val = COORD_W'($urandom_range(16'hffff));
      endcase
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= cbz_pkg::cfg_reg_t'(k);
      cfg_wdata <= val;
      ctrl_pt[k] = val;
    end
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    pt_sets++;
  endtask

  // mostly sweeps along a curve; the rest single, zero-count and clamped samples
  task automatic add_random_steps(int budget);
    int added, pick, n, i;
    added = 0;
    while (added < budget) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        n = $urandom_range(48, 1);
        for (i = 0; i <= n; i++) add_step(i, n);
        added += n + 1;
      end else if (pick < 70) begin
        add_step($urandom_range(4095), $urandom_range(4095));
        added++;
      end else if (pick < 80) begin
        add_step($urandom_range(4095), 0);
        added++;
      end else if (pick < 90) begin
        n = $urandom_range(4094, 1);
        add_step($urandom_range(4095, n + 1), n);
        added++;
      end else begin
        n = $urandom_range(4095, 2048);
        add_step((pick[0]) ? $urandom_range(7) : n - $urandom_range(7), n);
        added++;
      end
    end
  endtask

  initial begin : stimulus
    int ph;
    in_ch.valid      = 1'b0;
    in_ch.step_index = '0;
    in_ch.step_count = '0;
    out_ch.ready     = 1'b0;
    ctrl_pt[cbz_pkg::REG_P0_X] = 16'sd6400;
    ctrl_pt[cbz_pkg::REG_P0_Y] = 16'sd9600;
    ctrl_pt[cbz_pkg::REG_P1_X] = 16'sd8000;
    ctrl_pt[cbz_pkg::REG_P1_Y] = 16'sd3200;
    ctrl_pt[cbz_pkg::REG_P2_X] = 16'sd12800;
    ctrl_pt[cbz_pkg::REG_P2_Y] = 16'sd3200;
    ctrl_pt[cbz_pkg::REG_P3_X] = 16'sd14400;
    ctrl_pt[cbz_pkg::REG_P3_Y] = 16'sd9600;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed samples on the reset curve: zero count, clamped index, both ends
    add_step(0, 0);
    add_step(4095, 0);
    add_step(0, 1);
    add_step(1, 1);
    add_step(2, 1);
    add_step(4095, 1);
    add_step(0, 4095);
    add_step(1, 4095);
    add_step(2047, 4095);
    add_step(4094, 4095);
    add_step(4095, 4095);
    add_step(0, 3);
    add_step(1, 3);
    add_step(2, 3);
    add_step(3, 3);
    add_step(4095, 2048);
    add_step(2048, 4095);
    add_step(12'haaa, 12'hfff);
    add_step(12'h555, 12'haaa);
    add_step(12'haaa, 12'h555);
    add_step(7, 10);
    add_step(3, 7);
    wait_drained();

    for (ph = 1; ph <= PHASES; ph++) begin
      case (ph)
        1:       load_points(PTS_ALL_MAX);
        2:       load_points(PTS_ALL_MIN);
        3:       load_points(PTS_MIXED);
        default: load_points(PTS_RANDOM);
      endcase
      src_no_idle  = (ph == 4) || (ph == 6);
      sink_no_idle = (ph == 4);
      if (ph <= 3) begin
        add_step(0, 0);
        add_step(0, 4095);
        add_step(4095, 4095);
        add_step(1365, 4095);
        add_step(2730, 4095);
      end
      // hold the sink while the source keeps offering, so the pipe fills
      if (ph == 6) hold_arm++;
      add_random_steps(PHASE_ITEMS);
      wait_drained();
      src_no_idle  = 1'b0;
      sink_no_idle = 1'b0;
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (points_due.size() != 0) begin
      $display("%0d expected points never arrived", points_due.size());
      bad_cnt += points_due.size();
    end
    $display("covered %0d curve points over %0d control point sets (max, min, mixed, random)",
             points_seen, pt_sets);
    $display("zero-count %0d, clamped index %0d, input held off %0d cycles by a full pipe",
             zero_cnt_seen, clamp_seen, full_stall_cycles);
    if (bad_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[files.f]
src/cbz_pkg.sv
src/cbz_in_if.sv
src/cbz_out_if.sv
src/cbz_div.sv
src/cbz_weight.sv
src/cbz_mac.sv
src/cubic_bezier_point_eval.sv
verif/tb_top.sv
